/* hdl/mpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared types and constants of the multichannel pulse capture core.
// ----------------------------------------------------------------------------
package mpc_pkg;

    localparam int CHAN_COUNT   = 8;
    localparam int CH_IDX_W     = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
    localparam int CH_CMP_W     = 6;

    localparam int CMD_W     = 2;
    localparam int CHAN_W    = 3;
    localparam int COUNT_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int WIDTH_W   = 16;
    localparam int IDLE_W    = 21;
    localparam int RELOAD_W  = 16;
    localparam int CHUSE_W   = 4;
    localparam int TIMEOUT_W = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_EDGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADCH   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RELOAD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    localparam logic [RELOAD_W-1:0]  RELOAD_RST  = 16'hFFFF;
    localparam logic [CHUSE_W-1:0]   CHANS_RST   = 4'd8;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd100000;

    typedef struct packed {
        logic               awaiting_fall;
        logic [COUNT_W-1:0] rise_stamp;
        logic [WIDTH_W-1:0] width_store;
        logic               timed_out;
        logic [IDLE_W-1:0]  idle_time;
    } t_chan_state;

    localparam t_chan_state CHAN_RESET = '{
        awaiting_fall: 1'b0,
        rise_stamp:    '0,
        width_store:   '0,
        timed_out:     1'b1,
        idle_time:     '0
    };

endpackage

/* hdl/mpc_chan_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_chan_mem
// Per-channel state memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mpc_chan_mem
    import mpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [CH_IDX_W-1:0] i_rd_addr,
    output t_chan_state         o_rd_data,
    input  logic                i_wr_en,
    input  logic [CH_IDX_W-1:0] i_wr_addr,
    input  t_chan_state         i_wr_data
);

    t_chan_state                r_mem [CHAN_COUNT];
    t_chan_state                r_rd_data;
    logic [CH_IDX_W-1:0]        r_rd_addr;
    logic [CHAN_COUNT-1:0]      r_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // An entry never written reads as the channel's reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_vld[r_rd_addr] ? r_rd_data : CHAN_RESET;

endmodule

/* hdl/mpc_chan_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_chan_update
// Applies one command to one channel's state and forms the result.
// ----------------------------------------------------------------------------
module mpc_chan_update
    import mpc_pkg::*;
(
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [COUNT_W-1:0]   i_count,
    input  logic [RELOAD_W-1:0]  i_reload,
    input  logic [TIMEOUT_W-1:0] i_timeout,
    input  t_chan_state          i_cur,
    output t_chan_state          o_next,
    output logic [STATUS_W-1:0]  o_status,
    output logic [WIDTH_W-1:0]   o_width
);

    logic [IDLE_W:0]    idle_sum;
    logic [IDLE_W-1:0]  idle_sat;
    logic [WIDTH_W-1:0] fall_width;

    assign idle_sum = {1'b0, i_cur.idle_time} + (IDLE_W + 1)'(i_count);
    assign idle_sat = (idle_sum > {1'b0, IDLE_MAX}) ? IDLE_MAX : idle_sum[IDLE_W-1:0];

    // A fall that is not after its rise spans one counter wrap.
    assign fall_width = (i_count > i_cur.rise_stamp)
                      ? (i_count - i_cur.rise_stamp)
                      : (i_reload - i_cur.rise_stamp + i_count);

    always_comb begin
        o_next = i_cur;
        case (i_cmd)
            CMD_EDGE: begin
                if (!i_cur.awaiting_fall) begin
                    o_next.rise_stamp    = i_count;
                    o_next.idle_time     = '0;
                    o_next.awaiting_fall = 1'b1;
                end else begin
                    o_next.width_store   = fall_width;
                    o_next.timed_out     = 1'b0;
                    o_next.awaiting_fall = 1'b0;
                end
            end
            CMD_TICK: begin
                if (idle_sat >= IDLE_W'(i_timeout)) begin
                    o_next = CHAN_RESET;
                end else begin
                    o_next.idle_time = idle_sat;
                end
            end
            default: begin
                o_next = i_cur;
            end
        endcase

        if (o_next.timed_out) begin
            o_status = ST_TIMEOUT;
            o_width  = '0;
        end else begin
            o_status = ST_OK;
            o_width  = o_next.width_store;
        end
    end

endmodule

/* hdl/multichannel_pwm_pulse_capture_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_pwm_pulse_capture_core
// Pulse-width capture on several channels from capture, tick and read events.
// ----------------------------------------------------------------------------
// The core takes one transaction per clock while the output is not stalled,
// and returns one result for each through the update stage and the output
// register. Channel state lives in a single memory with a registered read;
// every transaction reads its channel on acceptance, updates it in the update
// stage and writes it back, and a one-entry bypass covers back-to-back
// transactions on the same channel. Per-entry valid bits give the reset state
// at once, so no clearing pass is needed after reset. Configuration registers
// must only be written while no transaction is in flight.
module multichannel_pwm_pulse_capture_core
    import mpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // [2:0] channel, [18:3] count
    input  logic [CMD_W-1:0]      s_axis_tuser,   // [1:0] cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [WIDTH_W-1:0]    m_axis_tdata,   // [15:0] pulse_width
    output logic [STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

    logic [RELOAD_W-1:0]   r_cfg_reload;
    logic [CHUSE_W-1:0]    r_cfg_chans;
    logic [TIMEOUT_W-1:0]  r_cfg_timeout;

    logic                  r_s1_valid;
    logic [CMD_W-1:0]      r_s1_cmd;
    logic [CHAN_W-1:0]     r_s1_ch;
    logic [COUNT_W-1:0]    r_s1_cnt;
    logic                  r_byp;
    t_chan_state           r_byp_data;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [WIDTH_W-1:0]    r_out_width;

    logic [CHAN_W-1:0]     in_ch;
    logic [COUNT_W-1:0]    in_cnt;
    logic                  in_acc;
    logic                  s1_adv;
    logic                  s1_bad;
    logic                  wr_en;
    t_chan_state           mem_rd;
    t_chan_state           cur;
    t_chan_state           upd_next;
    logic [STATUS_W-1:0]   upd_status;
    logic [WIDTH_W-1:0]    upd_width;

    assign in_ch  = s_axis_tdata[CHAN_W-1:0];
    assign in_cnt = s_axis_tdata[CHAN_W +: COUNT_W];

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign s1_bad = ({{(CH_CMP_W - CHAN_W){1'b0}}, r_s1_ch}
                        >= {{(CH_CMP_W - CHUSE_W){1'b0}}, r_cfg_chans})
                 || ({{(CH_CMP_W - CHAN_W){1'b0}}, r_s1_ch} >= CH_CMP_W'(CHAN_COUNT));

    assign wr_en = s1_adv && !s1_bad;
    assign cur   = r_byp ? r_byp_data : mem_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_reload  <= RELOAD_RST;
            r_cfg_chans   <= CHANS_RST;
            r_cfg_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RELOAD:  r_cfg_reload  <= i_cfg_data[RELOAD_W-1:0];
                REG_CHANS:   r_cfg_chans   <= i_cfg_data[CHUSE_W-1:0];
                REG_TIMEOUT: r_cfg_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    mpc_chan_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (CH_IDX_W'(in_ch)),
        .o_rd_data (mem_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (CH_IDX_W'(r_s1_ch)),
        .i_wr_data (upd_next)
    );

    mpc_chan_update u_upd (
        .i_cmd     (r_s1_cmd),
        .i_count   (r_s1_cnt),
        .i_reload  (r_cfg_reload),
        .i_timeout (r_cfg_timeout),
        .i_cur     (cur),
        .o_next    (upd_next),
        .o_status  (upd_status),
        .o_width   (upd_width)
    );

    // The memory read at acceptance misses a write-back at the same edge,
    // so that write is kept aside when it hits the incoming channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            r_byp      <= wr_en && (r_s1_ch == in_ch);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd   <= s_axis_tuser;
            r_s1_ch    <= in_ch;
            r_s1_cnt   <= in_cnt;
            r_byp_data <= upd_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_status <= s1_bad ? ST_BADCH : upd_status;
            r_out_width  <= s1_bad ? '0 : upd_width;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_width;
    assign m_axis_tuser  = r_out_status;

    a_bypass_only_with_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> r_s1_valid)
        else $error("bypass flag set with no item in the update stage");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted transaction did not reach the update stage");

    a_stalled_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_ch) && $stable(r_byp)))
        else $error("stalled update-stage item changed");

    a_width_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_width == '0))
        else $error("nonzero width reported with an error status");

    a_write_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_s1_valid && !s1_bad))
        else $error("state written without a valid item");

endmodule

/* test/capture_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_checker
// Tracks the pulse capture core's traffic and checks every result it returns.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the per-channel capture state and of the
// three configuration registers. It follows configuration writes, predicts the
// status and width for each accepted input transaction, and compares every
// accepted output transaction with the oldest prediction still waiting.
module capture_checker
    import mpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [23:0]          i_in_data,    // [2:0] channel, [18:3] count
    input  logic [CMD_W-1:0]     i_in_kind,    // [1:0] cmd
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [WIDTH_W-1:0]   i_out_width,  // [15:0] pulse_width
    input  logic [STATUS_W-1:0]  i_out_status, // [1:0] status
    output int                   o_mismatches,
    output int                   o_outstanding
);

    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [CHAN_W-1:0]   chan;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
        logic [WIDTH_W-1:0]  width;
    } t_capture_report;

    logic                 awaiting_fall [CHAN_COUNT];
    logic [COUNT_W-1:0]   rise_stamp    [CHAN_COUNT];
    logic [WIDTH_W-1:0]   width_store   [CHAN_COUNT];
    logic                 timed_out     [CHAN_COUNT];
    logic [IDLE_W-1:0]    idle_time     [CHAN_COUNT];

    logic [RELOAD_W-1:0]  reload_reg;
    logic [CHUSE_W-1:0]   chans_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    t_capture_report expected_reports[$];
    int              mismatch_total;

    function automatic void clear_channel_state(int idx);
        awaiting_fall[idx] = 1'b0;
        rise_stamp[idx]    = '0;
        width_store[idx]   = '0;
        timed_out[idx]     = 1'b1;
        idle_time[idx]     = '0;
    endfunction

    // Applies one event to the channel state and returns the report the core
    // should give for it.
    function automatic t_capture_report predict_capture(logic [CMD_W-1:0] cmd,
                                                        logic [CHAN_W-1:0] chan,
                                                        logic [COUNT_W-1:0] count);
        t_capture_report    rep;
        int                 idx;
        logic [WIDTH_W-1:0] span;
        logic [IDLE_W:0]    idle_sum;
        rep.cmd   = cmd;
        rep.chan  = chan;
        rep.count = count;
        idx       = int'(chan);
        if (idx >= int'(chans_reg) || idx >= CHAN_COUNT) begin
            rep.status = ST_BADCH;
            rep.width  = '0;
            return rep;
        end
        if (cmd == CMD_EDGE) begin
            if (!awaiting_fall[idx]) begin
                rise_stamp[idx]    = count;
                idle_time[idx]     = '0;
                awaiting_fall[idx] = 1'b1;
            end else begin
                // A fall that is not later than its rise spans one counter wrap.
                if (count > rise_stamp[idx])
                    span = count - rise_stamp[idx];
                else
                    span = reload_reg - rise_stamp[idx] + count;
                width_store[idx]   = span;
                timed_out[idx]     = 1'b0;
                awaiting_fall[idx] = 1'b0;
            end
        end else if (cmd == CMD_TICK) begin
            idle_sum = {1'b0, idle_time[idx]} + count;
            if (idle_sum > {1'b0, IDLE_MAX})
                idle_sum = {1'b0, IDLE_MAX};
            idle_time[idx] = idle_sum[IDLE_W-1:0];
            if (idle_time[idx] >= timeout_reg)
                clear_channel_state(idx);
        end
        if (timed_out[idx]) begin
            rep.status = ST_TIMEOUT;
            rep.width  = '0;
        end else begin
            rep.status = ST_OK;
            rep.width  = width_store[idx];
        end
        return rep;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_capture_report want;
        if (!i_rst_n) begin
            for (int i = 0; i < CHAN_COUNT; i++)
                clear_channel_state(i);
            reload_reg  = RELOAD_RST;
            chans_reg   = CHANS_RST;
            timeout_reg = TIMEOUT_RST;
            expected_reports.delete();
            mismatch_total = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RELOAD:  reload_reg  = i_cfg_data[RELOAD_W-1:0];
                    REG_CHANS:   chans_reg   = i_cfg_data[CHUSE_W-1:0];
                    REG_TIMEOUT: timeout_reg = i_cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_reports.push_back(predict_capture(i_in_kind,
                                                           i_in_data[CHAN_W-1:0],
                                                           i_in_data[CHAN_W +: COUNT_W]));
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= MAX_REPORTED)
                        $display("%0t: result status %0d width %0d arrived with none expected",
                                 $realtime, i_out_status, i_out_width);
                end else begin
                    want = expected_reports.pop_front();
                    if (want.status !== i_out_status || want.width !== i_out_width) begin
                        mismatch_total++;
                        if (mismatch_total <= MAX_REPORTED)
                            $display({"%0t: cmd %0d ch %0d count %0d: expected status %0d ",
                                      "width %0d, got status %0d width %0d"},
                                     $realtime, want.cmd, want.chan, want.count,
                                     want.status, want.width, i_out_status, i_out_width);
                    end
                end
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= expected_reports.size();
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the multichannel pulse capture core.
// ----------------------------------------------------------------------------
// A directed run covers the width arithmetic with and without a counter wrap,
// timeouts, invalid channels and the unused command code. Random phases then
// follow, each under its own register setting, with random gaps on the input
// and random stalls on the output, one long output hold-off and one full
// drain in the middle of a phase. The checker beside the core predicts and
// compares; this module only drives the core and reports the outcome.
module tb_top;
    import mpc_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 12;
    localparam int QUIET_LIMIT      = 2000;
    localparam int SINK_HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES    = 8;
    localparam int PHASES           = 8;
    localparam int PHASE_ITEMS      = 265;
    localparam int SHORT_PHASE      = 50;

    // The one command code the package leaves unnamed; the core treats it as a read.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;   // [2:0] channel, [18:3] count
    logic [CMD_W-1:0]     s_axis_tuser  = '0;   // [1:0] cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [WIDTH_W-1:0]   m_axis_tdata;         // [15:0] pulse_width
    logic [STATUS_W-1:0]  m_axis_tuser;         // [1:0] status

    int fail_count;
    int reports_waiting;
    int quiet_cycles = 0;
    int active_chans = 8;

    bit src_no_gaps   = 1'b0;
    bit sink_no_stall = 1'b0;
    bit sink_hold_req = 1'b0;

    multichannel_pwm_pulse_capture_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    capture_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_kind     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_width   (m_axis_tdata),
        .i_out_status  (m_axis_tuser),
        .o_mismatches  (fail_count),
        .o_outstanding (reports_waiting)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Mostly back-to-back, often a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] chan,
                              input logic [COUNT_W-1:0] count);
        int gap;
        gap = src_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, count, chan};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stops offering input until every predicted report has been returned.
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (reports_waiting != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input int reload, input int chans, input int timeout);
        write_reg(REG_RELOAD, CFG_DAT_W'(reload));
        write_reg(REG_CHANS, CFG_DAT_W'(chans));
        write_reg(REG_TIMEOUT, CFG_DAT_W'(timeout));
        i_cfg_we     <= 1'b0;
        active_chans  = chans;
    endtask

    task automatic random_event();
        int                 r;
        int                 top_chan;
        logic [CMD_W-1:0]   cmd;
        logic [CHAN_W-1:0]  chan;
        logic [COUNT_W-1:0] count;
        top_chan = (active_chans < 1) ? 0 : ((active_chans > 8) ? 7 : active_chans - 1);
        if ($urandom_range(0, 99) < 85)
            chan = CHAN_W'($urandom_range(0, top_chan));
        else
            chan = CHAN_W'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 45)
            cmd = CMD_EDGE;
        else if (r < 70)
            cmd = CMD_TICK;
        else if (r < 95)
            cmd = CMD_READ;
        else
            cmd = CMD_SPARE;
        r = $urandom_range(0, 99);
        if (cmd == CMD_TICK) begin
            if (r < 60)
                count = COUNT_W'($urandom_range(0, 2000));
            else if (r < 90)
                count = COUNT_W'($urandom_range(0, 65535));
            else
                count = 16'hFFFF;
        end else begin
            if (r < 5)
                count = '0;
            else if (r < 10)
                count = 16'hFFFF;
            else
                count = COUNT_W'($urandom_range(0, 65535));
        end
        send_event(cmd, chan, count);
    endtask

    // Output side: random stalls, stall-free phases, and one long hold-off on request.
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (sink_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end else if (sink_no_stall) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int items;
        int reload;
        int chans;
        int timeout;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset state: every channel starts out timed out.
        send_event(CMD_READ, 3'd0, 16'd0);
        send_event(CMD_SPARE, 3'd0, 16'd0);
        send_event(CMD_EDGE, 3'd0, 16'h0000);
        send_event(CMD_EDGE, 3'd0, 16'hFFFF);
        send_event(CMD_READ, 3'd0, 16'd0);
        // Fall below the rise, then fall equal to the rise.
        send_event(CMD_EDGE, 3'd1, 16'hFFFF);
        send_event(CMD_EDGE, 3'd1, 16'h0000);
        send_event(CMD_EDGE, 3'd1, 16'd1234);
        send_event(CMD_EDGE, 3'd1, 16'd1234);
        // Two full ticks pass the default timeout.
        send_event(CMD_TICK, 3'd1, 16'hFFFF);
        send_event(CMD_TICK, 3'd1, 16'hFFFF);
        send_event(CMD_READ, 3'd1, 16'd0);
        send_event(CMD_TICK, 3'd2, 16'd0);
        send_event(CMD_EDGE, 3'd7, 16'd5);
        send_event(CMD_TICK, 3'd7, 16'd1000);
        send_event(CMD_EDGE, 3'd7, 16'd9);
        send_event(CMD_READ, 3'd7, 16'hFFFF);
        drain_reports();

        // Zero reload, three channels, and a zero timeout that fires on any tick.
        load_settings(0, 3, 0);
        send_event(CMD_EDGE, 3'd3, 16'd10);
        send_event(CMD_READ, 3'd7, 16'd0);
        send_event(CMD_EDGE, 3'd2, 16'd100);
        send_event(CMD_EDGE, 3'd2, 16'd50);
        send_event(CMD_TICK, 3'd2, 16'd0);
        drain_reports();
        load_settings(65535, 0, 100000);
        send_event(CMD_READ, 3'd0, 16'd0);
        drain_reports();

        for (int phase = 0; phase < PHASES; phase++) begin
            items = PHASE_ITEMS;
            case (phase)
                0: begin reload = 65535; chans = 8; timeout = 100000; end
                1: begin reload = 0; chans = 1; timeout = 1; end
                2: begin reload = $urandom_range(0, 65535); chans = 8; timeout = 1048575; end
                3: begin
                    reload  = $urandom_range(0, 65535);
                    chans   = $urandom_range(1, 8);
                    timeout = $urandom_range(1, 5000);
                end
                4: begin reload = 65535; chans = 15; timeout = 0; end
                5: begin reload = 0; chans = 0; timeout = 1; items = SHORT_PHASE; end
                default: begin
                    reload  = $urandom_range(0, 65535);
                    chans   = $urandom_range(1, 8);
                    timeout = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 1048575)
                                                          : $urandom_range(1, 200000);
                end
            endcase
            load_settings(reload, chans, timeout);
            src_no_gaps   = (phase == 2) || ($urandom_range(0, 3) == 0);
            sink_no_stall = (phase == 0) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < items; n++) begin
                // The long hold-off lets the core fill up while input keeps coming.
                if (phase == 2 && n == 30)
                    sink_hold_req = 1'b1;
                if (phase == 3 && n == 120)
                    drain_reports();
                random_event();
            end
            drain_reports();
        end

        if (fail_count == 0 && reports_waiting == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
hdl/mpc_pkg.sv
hdl/mpc_chan_mem.sv
hdl/mpc_chan_update.sv
hdl/multichannel_pwm_pulse_capture_core.sv
test/capture_checker.sv
test/tb_top.sv
